/* hw/rtl/tkcm_pkg.sv */
// ----------------------------------------------------------------------------
// tkcm_pkg
// Shared types and constants of the three-knee contrast map: register
// indexes, reset levels and the knee set passed from the registers to lanes.
// ----------------------------------------------------------------------------
package tkcm_pkg;

  // widest channel the knee set can carry
  localparam int KNEE_BITS = 16;

  // apb address width: six word registers at byte addresses 0..20
  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  typedef enum logic [2:0] {
    REG_KNEE1_IN  = 3'd0,
    REG_KNEE1_OUT = 3'd1,
    REG_KNEE2_IN  = 3'd2,
    REG_KNEE2_OUT = 3'd3,
    REG_KNEE3_IN  = 3'd4,
    REG_KNEE3_OUT = 3'd5
  } reg_index_t;

  localparam logic [KNEE_BITS-1:0] KNEE1_RESET = KNEE_BITS'(64);
  localparam logic [KNEE_BITS-1:0] KNEE2_RESET = KNEE_BITS'(128);
  localparam logic [KNEE_BITS-1:0] KNEE3_RESET = KNEE_BITS'(192);

  typedef struct packed {
    logic [KNEE_BITS-1:0] knee1_in;
    logic [KNEE_BITS-1:0] knee1_out;
    logic [KNEE_BITS-1:0] knee2_in;
    logic [KNEE_BITS-1:0] knee2_out;
    logic [KNEE_BITS-1:0] knee3_in;
    logic [KNEE_BITS-1:0] knee3_out;
  } knees_t;

endpackage

/* hw/rtl/tkcm_regs.sv */
// ----------------------------------------------------------------------------
// tkcm_regs
// APB register file holding the three knee points of the tone curve.
// ----------------------------------------------------------------------------
module tkcm_regs #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tkcm_pkg::ADDR_BITS-1:0] paddr,
  input  logic [tkcm_pkg::DATA_BITS-1:0] pwdata,
  output logic [tkcm_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready,
  output tkcm_pkg::knees_t               knees
);
  import tkcm_pkg::*;

  localparam int N = CHANNEL_BITS;

  logic [N-1:0] knee1_in, knee1_out, knee2_in, knee2_out, knee3_in, knee3_out;
  logic [2:0]   index;
  logic         wr_en;
  logic [N-1:0] rd_level;

  assign index  = paddr[ADDR_BITS-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      knee1_in  <= KNEE1_RESET[N-1:0];
      knee1_out <= KNEE1_RESET[N-1:0];
      knee2_in  <= KNEE2_RESET[N-1:0];
      knee2_out <= KNEE2_RESET[N-1:0];
      knee3_in  <= KNEE3_RESET[N-1:0];
      knee3_out <= KNEE3_RESET[N-1:0];
    end else if (wr_en) begin
      // writes past the last register fall through
      unique case (index)
        REG_KNEE1_IN:  knee1_in  <= pwdata[N-1:0];
        REG_KNEE1_OUT: knee1_out <= pwdata[N-1:0];
        REG_KNEE2_IN:  knee2_in  <= pwdata[N-1:0];
        REG_KNEE2_OUT: knee2_out <= pwdata[N-1:0];
        REG_KNEE3_IN:  knee3_in  <= pwdata[N-1:0];
        REG_KNEE3_OUT: knee3_out <= pwdata[N-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_KNEE1_IN:  rd_level = knee1_in;
      REG_KNEE1_OUT: rd_level = knee1_out;
      REG_KNEE2_IN:  rd_level = knee2_in;
      REG_KNEE2_OUT: rd_level = knee2_out;
      REG_KNEE3_IN:  rd_level = knee3_in;
      REG_KNEE3_OUT: rd_level = knee3_out;
      default:       rd_level = '0;
    endcase
  end

  assign prdata = DATA_BITS'(rd_level);

  assign knees.knee1_in  = KNEE_BITS'(knee1_in);
  assign knees.knee1_out = KNEE_BITS'(knee1_out);
  assign knees.knee2_in  = KNEE_BITS'(knee2_in);
  assign knees.knee2_out = KNEE_BITS'(knee2_out);
  assign knees.knee3_in  = KNEE_BITS'(knee3_in);
  assign knees.knee3_out = KNEE_BITS'(knee3_out);

endmodule

/* hw/rtl/tkcm_div.sv */
// ----------------------------------------------------------------------------
// tkcm_div
// Pipelined restoring divider: one quotient bit per stage, N stages.
// The dividend must satisfy dividend < divisor * 2^N.
// ----------------------------------------------------------------------------
module tkcm_div #(
  parameter int CHANNEL_BITS = 8,
  parameter int TAG_BITS     = 9
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [2*CHANNEL_BITS-1:0] dividend,
  input  logic [CHANNEL_BITS-1:0]   divisor,
  input  logic [TAG_BITS-1:0]       in_tag,
  output logic                      out_valid,
  output logic [CHANNEL_BITS-1:0]   quotient,
  output logic [TAG_BITS-1:0]       out_tag
);
  import tkcm_pkg::*;

  localparam int N = CHANNEL_BITS;

  // work word: partial remainder on top, quotient bits shift in at the bottom
  wire [2*N-1:0]      work [N+1];
  wire [N-1:0]        dsor [N+1];
  wire [TAG_BITS-1:0] tag  [N+1];
  wire [N:0]          vld;

  assign work[0] = dividend;
  assign dsor[0] = divisor;
  assign tag[0]  = in_tag;
  assign vld[0]  = in_valid;

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [N:0]          trial;
    logic [N:0]          diff;
    logic                fits;
    logic [2*N-1:0]      work_q;
    logic [N-1:0]        dsor_q;
    logic [TAG_BITS-1:0] tag_q;
    logic                vld_q;

    assign trial = work[k][2*N-1:N-1];
    assign diff  = trial - {1'b0, dsor[k]};
    assign fits  = trial >= {1'b0, dsor[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (fits) begin
        work_q <= {diff[N-1:0], work[k][N-2:0], 1'b1};
      end else begin
        work_q <= {work[k][2*N-2:0], 1'b0};
      end
      dsor_q <= dsor[k];
      tag_q  <= tag[k];
    end

    assign work[k+1] = work_q;
    assign dsor[k+1] = dsor_q;
    assign tag[k+1]  = tag_q;
    assign vld[k+1]  = vld_q;
  end

  assign out_valid = vld[N];
  assign quotient  = work[N][N-1:0];
  assign out_tag   = tag[N];

endmodule

/* hw/rtl/tkcm_lane.sv */
// ----------------------------------------------------------------------------
// tkcm_lane
// One channel of the tone curve: segment pick, setup, multiply, divide and
// saturate, one stage each with the divider taking one stage per bit.
// ----------------------------------------------------------------------------
module tkcm_lane #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [CHANNEL_BITS-1:0] level_in,
  input  tkcm_pkg::knees_t        knees,
  output logic                    out_valid,
  output logic [CHANNEL_BITS-1:0] level_out
);
  import tkcm_pkg::*;

  localparam int N = CHANNEL_BITS;
  localparam logic [N-1:0] LEVEL_MAX = {N{1'b1}};

  logic [N-1:0] ka, kb, kc, ya, yb, yc;

  assign ka = knees.knee1_in[N-1:0];
  assign ya = knees.knee1_out[N-1:0];
  assign kb = knees.knee2_in[N-1:0];
  assign yb = knees.knee2_out[N-1:0];
  assign kc = knees.knee3_in[N-1:0];
  assign yc = knees.knee3_out[N-1:0];

  // stage 1: segment pick
  logic         zero_next;
  logic [N-1:0] x0_next, y0_next, x1_next, y1_next;
  logic         s1_valid, s1_zero;
  logic [N-1:0] s1_v, s1_x0, s1_y0, s1_x1, s1_y1;

  always_comb begin
    zero_next = 1'b0;
    priority if (level_in <= ka) begin
      // zero-width first segment maps to zero
      zero_next = (ka == '0);
      x0_next   = '0;
      y0_next   = '0;
      x1_next   = ka;
      y1_next   = zero_next ? '0 : ya;
    end else if (level_in <= kb) begin
      x0_next = ka;
      y0_next = ya;
      x1_next = kb;
      y1_next = yb;
    end else if (level_in <= kc) begin
      x0_next = kb;
      y0_next = yb;
      x1_next = kc;
      y1_next = yc;
    end else begin
      x0_next = kc;
      y0_next = yc;
      x1_next = LEVEL_MAX;
      y1_next = LEVEL_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_zero <= zero_next;
    s1_v    <= level_in;
    s1_x0   <= x0_next;
    s1_y0   <= y0_next;
    s1_x1   <= x1_next;
    s1_y1   <= y1_next;
  end

  // stage 2: run, offset and rise magnitude
  logic [N:0]   rise, rise_neg;
  logic         s2_valid, s2_neg;
  logic [N-1:0] s2_run, s2_dx, s2_mag, s2_y0;

  assign rise     = {1'b0, s1_y1} - {1'b0, s1_y0};
  assign rise_neg = -rise;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_run <= s1_zero ? N'(1) : s1_x1 - s1_x0;
    s2_dx  <= s1_v - s1_x0;
    s2_neg <= rise[N];
    s2_mag <= rise[N] ? rise_neg[N-1:0] : rise[N-1:0];
    s2_y0  <= s1_y0;
  end

  // stage 3: product
  logic           s3_valid, s3_neg;
  logic [2*N-1:0] s3_prod;
  logic [N-1:0]   s3_run, s3_y0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_prod <= s2_mag * s2_dx;
    s3_run  <= s2_run;
    s3_neg  <= s2_neg;
    s3_y0   <= s2_y0;
  end

  // divide magnitude, sign and start level ride along as the tag
  logic         dv_valid;
  logic [N-1:0] dv_quot;
  logic [N:0]   dv_tag;

  tkcm_div #(
    .CHANNEL_BITS(N),
    .TAG_BITS    (N + 1)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s3_valid),
    .dividend (s3_prod),
    .divisor  (s3_run),
    .in_tag   ({s3_neg, s3_y0}),
    .out_valid(dv_valid),
    .quotient (dv_quot),
    .out_tag  (dv_tag)
  );

  // last stage: add signed step to start level and clamp
  logic [N+1:0] step, step_neg, sum;
  logic [N-1:0] level_next;

  assign step     = {2'b00, dv_quot};
  assign step_neg = -step;
  assign sum      = {2'b00, dv_tag[N-1:0]} + (dv_tag[N] ? step_neg : step);

  always_comb begin
    priority if (sum[N+1]) begin
      level_next = '0;
    end else if (sum[N]) begin
      level_next = LEVEL_MAX;
    end else begin
      level_next = sum[N-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    level_out <= level_next;
  end

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> s2_run != '0)
    else $error("segment run is zero");

  a_offset_in_run: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> s2_dx <= s2_run)
    else $error("offset exceeds segment run");

  a_quotient_fits: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> s3_prod[2*N-1:N] < s3_run)
    else $error("quotient overflows channel width");

endmodule

/* hw/rtl/three_knee_contrast_map.sv */
// ----------------------------------------------------------------------------
// three_knee_contrast_map
// Piecewise linear contrast stretch of a three-channel pixel through a
// four-segment tone curve set by three knee points.
// ----------------------------------------------------------------------------
// One pixel is taken every clock: busy is never high. Each pixel comes out on
// blue_out/green_out/red_out with done high for one cycle, after passing the
// segment pick, setup and multiply stages, one divider stage per quotient
// bit, and the add and clamp stage. Results cannot be held off, so they must
// be taken in the cycle done is high. Knee registers sit at byte addresses
// 0, 4, 8, 12, 16, 20 (knee1 in/out, knee2 in/out, knee3 in/out) and should
// only be written with no pixel in flight.
module three_knee_contrast_map #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [CHANNEL_BITS-1:0]        blue_in,
  input  logic [CHANNEL_BITS-1:0]        green_in,
  input  logic [CHANNEL_BITS-1:0]        red_in,
  output logic                           done,
  output logic [CHANNEL_BITS-1:0]        blue_out,
  output logic [CHANNEL_BITS-1:0]        green_out,
  output logic [CHANNEL_BITS-1:0]        red_out,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tkcm_pkg::ADDR_BITS-1:0] paddr,
  input  logic [tkcm_pkg::DATA_BITS-1:0] pwdata,
  output logic [tkcm_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready
);
  import tkcm_pkg::*;

  knees_t knees;
  logic   accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  tkcm_regs #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .knees  (knees)
  );

  // all three lanes run in lockstep, blue lane supplies the strobe
  tkcm_lane #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_lane_blue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .level_in (blue_in),
    .knees    (knees),
    .out_valid(done),
    .level_out(blue_out)
  );

  tkcm_lane #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_lane_green (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .level_in (green_in),
    .knees    (knees),
    .out_valid(),
    .level_out(green_out)
  );

  tkcm_lane #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_lane_red (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .level_in (red_in),
    .knees    (knees),
    .out_valid(),
    .level_out(red_out)
  );

endmodule
